### rtl/nfasm_pkg.sv
// shared types and constants for the nfa state-set matcher
package nfasm_pkg;

  localparam int KIND_W     = 2;
  localparam int SYM_W      = 7;
  localparam int SRC_W      = 4;
  localparam int MASK_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_CONSUME = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEPT_MASK = 1'd0,
    CFG_START_STATE = 1'd1
  } cfg_idx_e;

endpackage

### rtl/nfasm_in_if.sv
// input channel: item kind, symbol, source state and destination mask
interface nfasm_in_if;
  import nfasm_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SYM_W-1:0]  symbol;
  logic [SRC_W-1:0]  source_state;
  logic [MASK_W-1:0] dest_mask;

  modport source (output valid, kind, symbol, source_state, dest_mask, input ready);
  modport sink   (input valid, kind, symbol, source_state, dest_mask, output ready);
endinterface

### rtl/nfasm_out_if.sv
// output channel: active set and accept flag
interface nfasm_out_if;
  import nfasm_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [MASK_W-1:0] active_states;

  modport source (output valid, accepted, active_states, input ready);
  modport sink   (input valid, accepted, active_states, output ready);
endinterface

### rtl/nfa_state_set_matcher_core.sv
// top level of the bit-parallel nfa state-set matcher
//
// usage:
//   in_i carries one item per transfer: a load ors dest_mask into the
//   transition entry (source_state, symbol), a restart makes start_state the
//   only active state, a consume steps the active set over one symbol.
//   out_o gives one result per item: the active set after it and whether
//   that set meets the accepting mask.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write accepting_mask (0) or
//   start_state (1); write only while no item is in flight.
// timing:
//   one item per cycle sustained while out_o.ready is high; a result passes
//   the read stage and then the output register before it shows on out_o.
//   the loop that sets the rate is the read-modify-write on one symbol row
//   of the transition memory (one row holds all source states' masks for a
//   symbol), plus the active set register fed back from the stage that ors
//   the row slices.
// reset:
//   active set, registers and all row valid bits clear at once, so the
//   table reads as zero right away; no clearing pass is needed.
// stall:
//   the output register holds its result while out_o.ready is low; one
//   more item can sit in the read stage, then in_i.ready drops.
module nfa_state_set_matcher_core #(
  parameter int STATE_CNT     = 16,
  parameter int ALPHABET_SIZE = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  nfasm_in_if.sink                         in_i,
  nfasm_out_if.source                      out_o,
  input  logic                             cfg_we_i,
  input  logic [nfasm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nfasm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  import nfasm_pkg::*;

  // states reachable through the fixed-width fields
  localparam int SW = (STATE_CNT < MASK_W) ? STATE_CNT : MASK_W;
  // symbol rows reachable through the 7-bit symbol field
  localparam int NR = (ALPHABET_SIZE < (1 << SYM_W)) ? ALPHABET_SIZE : (1 << SYM_W);
  localparam int AW = (NR > 1) ? $clog2(NR) : 1;
  localparam int RW = SW * SW;

  // configuration
  logic [SW-1:0]    acc_mask_q;
  logic [SRC_W-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_mask_q <= '0;
      start_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEPT_MASK: acc_mask_q <= cfg_wdata_i[SW-1:0];
        CFG_START_STATE: start_q    <= cfg_wdata_i[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic in_acc;
  logic out_free;
  logic s1_adv;
  logic s1_vld_q;
  logic out_vld_q;

  assign out_free   = !out_vld_q || out_o.ready;
  assign s1_adv     = s1_vld_q && out_free;
  assign in_i.ready = !s1_vld_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  // read stage decode
  logic [AW-1:0] rd_addr;
  logic          sym_ok;
  logic          src_ok;

  assign rd_addr = in_i.symbol[AW-1:0];
  assign sym_ok  = int'(in_i.symbol) < ALPHABET_SIZE;
  assign src_ok  = int'(in_i.source_state) < STATE_CNT;

  // transition memory: one row per symbol, SW slices of SW bits
  logic [RW-1:0] mem_q [NR];
  logic [RW-1:0] rd_q;
  logic [NR-1:0] row_vld_q;
  logic          rvld_q;

  // write-back from the compute stage
  logic          we;
  logic [RW-1:0] wr_row;
  logic [AW-1:0] s1_row_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[s1_row_q] <= wr_row;
    end
    if (in_acc) begin
      rd_q   <= mem_q[rd_addr];
      rvld_q <= row_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (we) begin
      row_vld_q[s1_row_q] <= 1'b1;
    end
  end

  // compute stage registers
  kind_e            s1_kind_q;
  logic [SRC_W-1:0] s1_src_q;
  logic [SW-1:0]    s1_dst_q;
  logic             s1_ok_q;
  logic             byp_q;
  logic [RW-1:0]    byp_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_kind_q <= kind_e'(in_i.kind);
      s1_row_q  <= rd_addr;
      s1_src_q  <= in_i.source_state;
      s1_dst_q  <= in_i.dest_mask[SW-1:0];
      // loads need both fields in range, consumes only the symbol
      s1_ok_q   <= (kind_e'(in_i.kind) == KIND_LOAD) ? (sym_ok && src_ok) : sym_ok;
      // the row written at this edge is not yet seen by the read
      byp_q     <= we && (s1_row_q == rd_addr);
      byp_row_q <= wr_row;
    end
  end

  // active set doubles as the output payload
  logic [SW-1:0] act_q;
  logic [SW-1:0] act_d;
  logic          out_acc_q;
  logic [RW-1:0] eff_row;
  logic [SW-1:0] nxt;
  logic          start_ok;

  assign eff_row  = byp_q ? byp_row_q : (rvld_q ? rd_q : '0);
  assign start_ok = int'(start_q) < STATE_CNT;

  // or the slices of all active source states; merge the load mask
  always_comb begin
    nxt    = '0;
    wr_row = eff_row;
    for (int s = 0; s < SW; s++) begin
      if (act_q[s]) begin
        nxt = nxt | eff_row[s*SW +: SW];
      end
      if (s1_src_q == SRC_W'(s)) begin
        wr_row[s*SW +: SW] = eff_row[s*SW +: SW] | s1_dst_q;
      end
    end
  end

  assign we = s1_adv && (s1_kind_q == KIND_LOAD) && s1_ok_q;

  always_comb begin
    case (s1_kind_q)
      KIND_LOAD:    act_d = act_q;
      KIND_RESTART: act_d = start_ok ? (SW'(1) << start_q) : '0;
      KIND_CONSUME: act_d = s1_ok_q ? nxt : '0;
      default:      act_d = act_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      act_q     <= act_d;
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_acc_q <= |(act_d & acc_mask_q);
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.accepted      = out_acc_q;
  assign out_o.active_states = MASK_W'(act_q);

endmodule

### rtl/nfasm_checker.sv
// port-level checks for the nfa state-set matcher, bound to the top level
module nfasm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic [nfasm_pkg::KIND_W-1:0]     in_kind_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             out_accepted_i,
  input logic [nfasm_pkg::MASK_W-1:0]     out_active_i
);

  import nfasm_pkg::*;

  logic restart_xfer;
  assign restart_xfer = in_valid_i && in_ready_i && (kind_e'(in_kind_i) == KIND_RESTART);

  // held result does not change under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_active_i)
      && $stable(out_accepted_i))
    else $error("output changed while stalled");

  // an empty set can never be accepting
  a_acc_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_accepted_i |-> out_active_i != '0)
    else $error("accepted with no active state");

  // restart result is at most one-hot and is valid once it has left the read stage with out_ready high
  a_restart_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart_xfer ##1 out_ready_i |=> out_valid_i && $onehot0(out_active_i))
    else $error("restart result missing or not one-hot");

  // nothing is shown right out of reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("output valid right after reset");

endmodule

bind nfa_state_set_matcher_core nfasm_checker u_nfasm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_kind_i      (in_i.kind),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_accepted_i (out_o.accepted),
  .out_active_i   (out_o.active_states)
);

### verif/nfa_state_set_matcher_core_tb.sv
// self-checking testbench for the nfa state-set matcher core
module nfa_state_set_matcher_core_tb;
  import nfasm_pkg::*;

  // block size as built (defaults of the core)
  localparam int N_STATES  = 16;
  localparam int N_SYMBOLS = 128;

  // kind code that the block must treat as a no-op
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // settle time after the last result, before touching registers
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 10;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic              accepted;
    logic [MASK_W-1:0] active;
  } nfa_result_t;

  logic clk_i;
  logic rst_ni;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nfasm_in_if  in_ch ();
  nfasm_out_if out_ch ();

  nfa_state_set_matcher_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // shadow of the automaton: transition masks, active set, registers
  logic [MASK_W-1:0] trans_tbl [N_STATES][N_SYMBOLS];
  logic [MASK_W-1:0] nfa_active;
  logic [MASK_W-1:0] accept_mask;
  logic [SRC_W-1:0]  start_st;

  // results predicted but not yet seen on the output channel
  nfa_result_t pending_results[$];

  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit rx_hold        = 1'b0;

  // clock, period 2
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off while rx_hold is set
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // step the shadow automaton by one accepted item and queue its result
  function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                       input logic [SYM_W-1:0]  sym,
                                       input logic [SRC_W-1:0]  src,
                                       input logic [MASK_W-1:0] mask);
    nfa_result_t       res;
    logic [MASK_W-1:0] nxt;
    nxt = '0;
    case (kind)
      KIND_LOAD: trans_tbl[src][sym] = trans_tbl[src][sym] | mask;
      KIND_RESTART: nfa_active = MASK_W'(1) << start_st;
      KIND_CONSUME: begin
        // union of the entries of every active state for this symbol
        for (int s = 0; s < N_STATES; s++)
          if (nfa_active[s]) nxt = nxt | trans_tbl[s][sym];
        nfa_active = nxt;
      end
      default: ; // unused kind leaves everything alone
    endcase
    res.accepted = |(nfa_active & accept_mask);
    res.active   = nfa_active;
    pending_results.push_back(res);
  endfunction

  // result checker: every output transfer against the oldest prediction
  always @(posedge clk_i) begin : result_check
    nfa_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: expected none, actual accepted=%0b active=%h",
                 $time, out_ch.accepted, out_ch.active_states);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.accepted !== want.accepted) begin
          err_cnt++;
          $display("%0t: accepted mismatch: expected %0b, actual %0b",
                   $time, want.accepted, out_ch.accepted);
        end
        if (out_ch.active_states !== want.active) begin
          err_cnt++;
          $display("%0t: active_states mismatch: expected %h, actual %h",
                   $time, want.active, out_ch.active_states);
        end
      end
    end
  end

  // one input transfer; valid stays high afterwards so back-to-back items
  // never see valid dropped and raised in the same step
  task automatic send_item(input logic [KIND_W-1:0] kind,
                           input logic [SYM_W-1:0]  sym,
                           input logic [SRC_W-1:0]  src,
                           input logic [MASK_W-1:0] mask);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.symbol       <= sym;
    in_ch.source_state <= src;
    in_ch.dest_mask    <= mask;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_item(kind, sym, src, mask);
  endtask

  // stop offering items and wait until every result has come back
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ACCEPT_MASK: accept_mask = data;
      CFG_START_STATE: start_st    = data[SRC_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [MASK_W-1:0] acc, input logic [SRC_W-1:0] st);
    drain();
    write_reg(CFG_ACCEPT_MASK, acc);
    write_reg(CFG_START_STATE, CFG_DATA_W'(st));
  endtask

  // one or two destination states, so active sets stay interesting
  function automatic logic [MASK_W-1:0] sparse_mask();
    logic [MASK_W-1:0] m;
    m = MASK_W'(1) << $urandom_range(0, N_STATES - 1);
    if ($urandom_range(0, 2) == 0) m = m | (MASK_W'(1) << $urandom_range(0, N_STATES - 1));
    return m;
  endfunction

  // mostly restart-then-string sequences over a small alphabet with a few
  // sparse loads mixed in; the rest is fully random noise
  task automatic run_traffic(input int n_items);
    int                sent;
    int                pick;
    int                len;
    logic [SYM_W-1:0]  base;
    sent = 0;
    base = SYM_W'($urandom_range(0, N_SYMBOLS - 4));
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // grow the automaton a little
        len = $urandom_range(1, 3);
        repeat (len) begin
          send_item(KIND_LOAD, base + SYM_W'($urandom_range(0, 3)),
                    SRC_W'($urandom_range(0, N_STATES - 1)), sparse_mask());
          sent++;
        end
      end else if (pick < 85) begin
        // restart, then run a string through it
        send_item(KIND_RESTART, SYM_W'($urandom), SRC_W'($urandom), MASK_W'($urandom));
        sent++;
        len = $urandom_range(1, 10);
        repeat (len) begin
          send_item(KIND_CONSUME, base + SYM_W'($urandom_range(0, 3)),
                    SRC_W'($urandom), MASK_W'($urandom));
          sent++;
        end
      end else begin
        send_item(KIND_W'($urandom_range(0, 3)), SYM_W'($urandom),
                  SRC_W'($urandom), MASK_W'($urandom));
        sent++;
      end
    end
  endtask

  // corner cases: empty set at reset, table extremes, or-accumulation,
  // symbol zero, unused kind, load keeping the set, both start extremes
  task automatic test_directed();
    send_item(KIND_CONSUME, 7'd0, 4'd0, 16'h0000);  // empty set stays empty
    send_item(KIND_UNUSED, 7'd0, 4'd0, 16'h0000);
    send_item(KIND_RESTART, 7'd0, 4'd0, 16'h0000);  // accept mask still zero
    set_config(16'h8001, 4'd0);
    send_item(KIND_RESTART, 7'h7f, 4'hf, 16'hffff);
    send_item(KIND_LOAD, 7'd0, 4'd0, 16'hffff);
    send_item(KIND_LOAD, 7'h7f, 4'hf, 16'h8000);
    send_item(KIND_LOAD, 7'd0, 4'hf, 16'h0000);
    send_item(KIND_LOAD, 7'h7f, 4'd0, 16'h5555);
    send_item(KIND_LOAD, 7'h7f, 4'd0, 16'haaaa);    // or into the same entry
    send_item(KIND_LOAD, 7'h2a, 4'ha, 16'h0400);
    send_item(KIND_CONSUME, 7'd0, 4'd0, 16'h0000);  // symbol zero fans out
    send_item(KIND_CONSUME, 7'h7f, 4'hf, 16'hffff);
    send_item(KIND_CONSUME, 7'h2a, 4'd0, 16'h0000); // only state 10 survives
    send_item(KIND_CONSUME, 7'h2a, 4'd0, 16'h0000);
    send_item(KIND_CONSUME, 7'h01, 4'd0, 16'h0000); // dead end
    send_item(KIND_CONSUME, 7'd0, 4'd0, 16'h0000);  // empty until restart
    send_item(KIND_UNUSED, 7'h7f, 4'hf, 16'hffff);
    send_item(KIND_RESTART, 7'd0, 4'd0, 16'h0000);
    send_item(KIND_UNUSED, 7'h55, 4'h5, 16'h5555);
    send_item(KIND_LOAD, 7'h33, 4'h3, 16'h0008);    // set reported unchanged
    set_config(16'h8000, 4'hf);
    send_item(KIND_RESTART, 7'd0, 4'd0, 16'h0000);
    send_item(KIND_CONSUME, 7'h7f, 4'd0, 16'h0000);
    set_config(16'h0000, 4'd0);
    send_item(KIND_RESTART, 7'd0, 4'd0, 16'h0000);
  endtask

  // full throughput on both sides
  task automatic test_no_idle();
    set_config(16'hffff, 4'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_traffic(420);
  endtask

  // gaps on the input channel only
  task automatic test_sender_gaps();
    set_config(16'h0001, 4'hf);
    send_idle_pct  = 51;
    recv_stall_pct = 0;
    run_traffic(420);
  endtask

  // stalls on the output channel only
  task automatic test_receiver_stalls();
    set_config(MASK_W'($urandom), SRC_W'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 51;
    run_traffic(420);
  endtask

  // light gaps and stalls on both sides
  task automatic test_both_idle();
    set_config(MASK_W'($urandom), SRC_W'($urandom));
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    run_traffic(420);
  endtask

  // long receiver hold-off while items keep coming: the pipe fills and
  // the input side must stall without losing or reordering anything
  task automatic test_backpressure();
    set_config(MASK_W'($urandom), SRC_W'($urandom));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (300) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    run_traffic(40);
  endtask

  initial begin
    // known values on every input from time zero
    rst_ni                = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = CFG_ACCEPT_MASK;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.kind            = KIND_LOAD;
    in_ch.symbol          = '0;
    in_ch.source_state    = '0;
    in_ch.dest_mask       = '0;

    // shadow reset: table cleared, no state active, registers zero
    for (int s = 0; s < N_STATES; s++)
      for (int c = 0; c < N_SYMBOLS; c++)
        trans_tbl[s][c] = '0;
    nfa_active  = '0;
    accept_mask = '0;
    start_st    = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();

    // wait for the last results, then a few quiet cycles
    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
rtl/nfasm_pkg.sv
rtl/nfasm_in_if.sv
rtl/nfasm_out_if.sv
rtl/nfa_state_set_matcher_core.sv
rtl/nfasm_checker.sv
verif/nfa_state_set_matcher_core_tb.sv
